// ===== hdl/ffa_pkg.sv =====
`timescale 1ns / 1ps

package ffa_pkg;

	localparam int BYTE_W = 8;
	localparam int FRAME_LEN_DEF = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [BYTE_W-1:0] HEADER_FIRST_RST = 8'h3F;
	localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h21;
	localparam logic [BYTE_W-1:0] TRAILER_RST = 8'h21;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEADER_FIRST,
		REG_HEADER_SECOND,
		REG_TRAILER
	} cfg_reg_t;

endpackage

// ===== hdl/ffa_mem.sv =====
`timescale 1ns / 1ps

module ffa_mem #(
	parameter int DEPTH = ffa_pkg::FRAME_LEN_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [ADDR_W-1:0]         waddr,
	input  logic [ffa_pkg::BYTE_W-1:0] wdata,
	input  logic                      re_a,
	input  logic [ADDR_W-1:0]         raddr_a,
	output logic [ffa_pkg::BYTE_W-1:0] rdata_a,
	input  logic                      re_b,
	input  logic [ADDR_W-1:0]         raddr_b,
	output logic [ffa_pkg::BYTE_W-1:0] rdata_b
);
	import ffa_pkg::*;

	logic [BYTE_W-1:0] mem_q [DEPTH];
	logic [BYTE_W-1:0] rdata_a_q;
	logic [BYTE_W-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read data holds while its enable is low, so port A can serve as the output register.
	always_ff @(posedge clk) begin
		if (re_a) begin
			rdata_a_q <= mem_q[raddr_a];
		end
		if (re_b) begin
			rdata_b_q <= mem_q[raddr_b];
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

// ===== hdl/fixed_frame_aligner.sv =====
`timescale 1ns / 1ps
// Fixed-length frame aligner.
// Bytes enter on the rx channel (rx_valid/rx_ready, payload rx_byte) and are kept
// in a ring memory of FRAME_LEN entries. When the window is full, the oldest and
// second oldest bytes are read from the memory and checked against header_first
// and header_second, and the newest byte against trailer. On a match the frame
// leaves on the frame channel (frame_valid/frame_ready, payload frame_byte and
// frame_last) oldest first, one byte per cycle while frame_ready is high, with
// frame_last on the final byte. On a mismatch the oldest byte is dropped and the
// search continues. Sequence: the byte that completes the window is accepted,
// then checked in the check state on the registered memory reads. A matching
// frame then streams in the emit state, one memory read per byte on the shared
// read port, during which no byte is accepted; the emit state reads the first
// frame byte into the port A read register after the check state.
// If the receiver stalls, the output byte holds in the memory read register and
// the stream pauses. Filling continues while the last frame byte waits, up to the
// byte that would complete the next window.
// Reset empties the window and loads the default header and trailer bytes; the
// memory contents are not cleared. Configuration writes take effect at once.

module fixed_frame_aligner #(
	parameter int FRAME_LEN = ffa_pkg::FRAME_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [ffa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ffa_pkg::BYTE_W-1:0]    cfg_data,
	input  logic                          rx_valid,
	output logic                          rx_ready,
	input  logic [ffa_pkg::BYTE_W-1:0]    rx_byte,
	output logic                          frame_valid,
	input  logic                          frame_ready,
	output logic [ffa_pkg::BYTE_W-1:0]    frame_byte,
	output logic                          frame_last
);
	import ffa_pkg::*;

	localparam int PTR_W = $clog2(FRAME_LEN);
	localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(FRAME_LEN - 1);

	typedef enum logic [1:0] {
		ST_FILL,
		ST_CHECK,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic [PTR_W-1:0]  fill_q;
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  wp_q;
	logic [PTR_W-1:0]  rp_q;
	logic [PTR_W-1:0]  emit_cnt_q;
	logic [BYTE_W-1:0] newest_q;
	logic [BYTE_W-1:0] header_first_q;
	logic [BYTE_W-1:0] header_second_q;
	logic [BYTE_W-1:0] trailer_q;
	logic              out_valid_q;
	logic              out_last_q;

	logic              accept;
	logic              full_acc;
	logic              emit_re;
	logic              hit;
	logic              re_a;
	logic [PTR_W-1:0]  raddr_a;
	logic [BYTE_W-1:0] rdata_a;
	logic [BYTE_W-1:0] rdata_b;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == LAST_IDX) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	// The byte that completes a window needs the read register of port A, so it
	// waits until the last byte of the previous frame has been taken.
	assign rx_ready = (state_q == ST_FILL) && !((fill_q == LAST_IDX) && out_valid_q);
	assign accept   = rx_valid && rx_ready;
	assign full_acc = accept && (fill_q == LAST_IDX);
	assign emit_re  = (state_q == ST_EMIT) && (!out_valid_q || frame_ready);
	assign re_a     = full_acc || emit_re;
	assign raddr_a  = full_acc ? head_q : rp_q;
	assign hit      = (rdata_a == header_first_q) && (rdata_b == header_second_q) &&
	                  (newest_q == trailer_q);

	ffa_mem #(
		.DEPTH  (FRAME_LEN),
		.ADDR_W (PTR_W)
	) u_mem (
		.clk     (clk),
		.we      (accept),
		.waddr   (wp_q),
		.wdata   (rx_byte),
		.re_a    (re_a),
		.raddr_a (raddr_a),
		.rdata_a (rdata_a),
		.re_b    (full_acc),
		.raddr_b (ptr_inc(head_q)),
		.rdata_b (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_FILL;
			fill_q          <= '0;
			head_q          <= '0;
			wp_q            <= '0;
			rp_q            <= '0;
			emit_cnt_q      <= '0;
			newest_q        <= '0;
			header_first_q  <= HEADER_FIRST_RST;
			header_second_q <= HEADER_SECOND_RST;
			trailer_q       <= TRAILER_RST;
			out_valid_q     <= 1'b0;
			out_last_q      <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_HEADER_FIRST:  header_first_q  <= cfg_data;
					REG_HEADER_SECOND: header_second_q <= cfg_data;
					REG_TRAILER:       trailer_q       <= cfg_data;
					default: ;
				endcase
			end

			if (emit_re) begin
				out_valid_q <= 1'b1;
				out_last_q  <= (emit_cnt_q == LAST_IDX);
			end else if (frame_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_FILL: begin
					if (accept) begin
						wp_q <= ptr_inc(wp_q);
						if (fill_q == LAST_IDX) begin
							newest_q <= rx_byte;
							state_q  <= ST_CHECK;
						end else begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				ST_CHECK: begin
					// With a full window the write pointer equals the head, so only
					// the head moves on a mismatch and the fill stays one short.
					if (hit) begin
						rp_q       <= head_q;
						emit_cnt_q <= '0;
						fill_q     <= '0;
						state_q    <= ST_EMIT;
					end else begin
						head_q  <= ptr_inc(head_q);
						state_q <= ST_FILL;
					end
				end
				ST_EMIT: begin
					if (emit_re) begin
						rp_q       <= ptr_inc(rp_q);
						emit_cnt_q <= emit_cnt_q + 1'b1;
						if (emit_cnt_q == LAST_IDX) begin
							state_q <= ST_FILL;
						end
					end
				end
				default: state_q <= ST_FILL;
			endcase
		end
	end

	assign frame_valid = out_valid_q;
	assign frame_byte  = rdata_a;
	assign frame_last  = out_last_q;

	a_check_no_output: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> !out_valid_q)
		else $error("output pending while the window check uses the read register");

	a_full_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		full_acc |=> (state_q == ST_CHECK))
		else $error("completed window was not checked");

	a_emit_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (fill_q == '0))
		else $error("window not emptied during frame output");

	a_last_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_re && (emit_cnt_q == LAST_IDX)) |=> (frame_last && frame_valid &&
		(state_q == ST_FILL)))
		else $error("final frame byte not marked");

endmodule

// ===== verif/fixed_frame_aligner_test.sv =====
`timescale 1ns / 1ps

module fixed_frame_aligner_test;
	import ffa_pkg::*;

	localparam int FRAME_LEN = FRAME_LEN_DEF;
	localparam int PHASE_BYTES = 45;
	localparam int NUM_PHASES = 5;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_PRINTS = 30;
	// Index past the register list; the block must ignore writes to it.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} frame_beat_t;

	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic              ends_frame;
	} stim_row_t;

	// Three noise bytes (the last one a lone header byte), then one frame built
	// from the reset header and trailer, with both byte extremes inside it.
	localparam int DIR_ROWS = 19;
	stim_row_t dir_rows [DIR_ROWS] = '{
		'{8'h00, 1'b0}, '{8'hFF, 1'b0}, '{8'h3F, 1'b0},
		'{8'h3F, 1'b0}, '{8'h21, 1'b0}, '{8'h00, 1'b0}, '{8'hFF, 1'b0},
		'{8'h55, 1'b0}, '{8'hAA, 1'b0}, '{8'h01, 1'b0}, '{8'h80, 1'b0},
		'{8'h7F, 1'b0}, '{8'hFE, 1'b0}, '{8'h21, 1'b0}, '{8'h3F, 1'b0},
		'{8'h10, 1'b0}, '{8'hC3, 1'b0}, '{8'h5A, 1'b0}, '{8'h21, 1'b1}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0]    cfg_data;
	logic                 rx_valid;
	logic                 rx_ready;
	logic [BYTE_W-1:0]    rx_byte;
	logic                 frame_valid;
	logic                 frame_ready;
	logic [BYTE_W-1:0]    frame_byte;
	logic                 frame_last;

	logic [BYTE_W-1:0] hdr_first_q;
	logic [BYTE_W-1:0] hdr_second_q;
	logic [BYTE_W-1:0] trailer_q;
	logic [BYTE_W-1:0] window [FRAME_LEN];
	int                window_fill;
	frame_beat_t       pending_frame_bytes [$];

	int  errors;
	int  bytes_sent;
	int  beats_checked;
	int  settings_used;
	bit  quiet;

	fixed_frame_aligner #(
		.FRAME_LEN(FRAME_LEN)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.rx_valid   (rx_valid),
		.rx_ready   (rx_ready),
		.rx_byte    (rx_byte),
		.frame_valid(frame_valid),
		.frame_ready(frame_ready),
		.frame_byte (frame_byte),
		.frame_last (frame_last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [BYTE_W-1:0] value);
		case (idx)
			REG_HEADER_FIRST: hdr_first_q = value;
			REG_HEADER_SECOND: hdr_second_q = value;
			REG_TRAILER: trailer_q = value;
			default: ;
		endcase
	endfunction

	// Shifts one byte into the window and queues the whole frame on a match.
	// Returns the number of frame bytes the byte released.
	function automatic int advance_window(input logic [BYTE_W-1:0] b);
		frame_beat_t beat;
		bit hit;
		if (window_fill >= FRAME_LEN)
			window_fill = FRAME_LEN - 1;
		window[window_fill] = b;
		window_fill++;
		if (window_fill < FRAME_LEN)
			return 0;
		hit = window[0] == hdr_first_q && window[1] == hdr_second_q &&
			window[FRAME_LEN-1] == trailer_q;
		if (hit) begin
			for (int i = 0; i < FRAME_LEN; i++) begin
				beat.data = window[i];
				beat.last = (i == FRAME_LEN - 1);
				pending_frame_bytes.push_back(beat);
			end
			window_fill = 0;
			return FRAME_LEN;
		end
		for (int i = 0; i < FRAME_LEN - 1; i++)
			window[i] = window[i+1];
		window_fill = FRAME_LEN - 1;
		return 0;
	endfunction

	// Mostly short gaps, now and then a long one; none at all in quiet phases.
	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_byte(input logic [BYTE_W-1:0] b, output int produced);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!rx_ready);
		produced = advance_window(b);
		bytes_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		apply_reg(idx, value);
	endtask

	task automatic load_regs(input logic [BYTE_W-1:0] hf, input logic [BYTE_W-1:0] hs,
			input logic [BYTE_W-1:0] tr);
		write_reg(REG_HEADER_FIRST, hf);
		write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
		write_reg(REG_HEADER_SECOND, hs);
		write_reg(REG_TRAILER, tr);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	// Waits until every expected frame byte has come out and the last window
	// check has had time to finish.
	task automatic settle();
		rx_valid <= 1'b0;
		while (pending_frame_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly well-formed frames with random payload, the rest frames with one
	// checked position spoiled and short runs of noise.
	task automatic send_random(input int count);
		logic [BYTE_W-1:0] seq [$];
		int sent;
		int r;
		int pos;
		int produced;
		sent = 0;
		while (sent < count) begin
			seq.delete();
			r = $urandom_range(0, 99);
			if (r < 82) begin
				seq.push_back(hdr_first_q);
				seq.push_back(hdr_second_q);
				for (int i = 2; i < FRAME_LEN - 1; i++)
					seq.push_back(8'($urandom_range(0, 255)));
				seq.push_back(trailer_q);
				if (r >= 65) begin
					pos = $urandom_range(0, 2);
					if (pos == 2)
						pos = FRAME_LEN - 1;
					seq[pos] = seq[pos] ^ 8'($urandom_range(1, 255));
				end
			end else begin
				repeat ($urandom_range(1, 5))
					seq.push_back(8'($urandom_range(0, 255)));
			end
			foreach (seq[i])
				send_byte(seq[i], produced);
			sent += seq.size();
		end
	endtask

	task automatic check_beat();
		frame_beat_t want;
		if (pending_frame_bytes.size() == 0) begin
			report_mismatch($sformatf("frame byte %02h arrived with nothing expected",
				frame_byte));
			return;
		end
		want = pending_frame_bytes.pop_front();
		if (frame_byte !== want.data)
			report_mismatch($sformatf("frame_byte %02h, expected %02h", frame_byte, want.data));
		if (frame_last !== want.last)
			report_mismatch($sformatf("frame_last %b, expected %b", frame_last, want.last));
		beats_checked++;
	endtask

	initial begin
		int stall;
		stall = 0;
		frame_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && frame_valid && frame_ready)
				check_beat();
			if (stall > 0) begin
				frame_ready <= 1'b0;
				stall--;
			end else begin
				frame_ready <= 1'b1;
				if ($urandom_range(0, 99) < 30)
					stall = pick_gap();
			end
		end
	end

	initial begin
		int produced;
		logic [BYTE_W-1:0] hf;
		logic [BYTE_W-1:0] hs;
		logic [BYTE_W-1:0] tr;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_HEADER_FIRST;
		cfg_data <= '0;
		rx_valid <= 1'b0;
		rx_byte <= '0;
		errors = 0;
		bytes_sent = 0;
		beats_checked = 0;
		settings_used = 1;
		quiet = 0;
		hdr_first_q = HEADER_FIRST_RST;
		hdr_second_q = HEADER_SECOND_RST;
		trailer_q = TRAILER_RST;
		window_fill = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			send_byte(dir_rows[i].value, produced);
			if (produced != (dir_rows[i].ends_frame ? FRAME_LEN : 0))
				report_mismatch($sformatf("row %0d released %0d frame bytes", i, produced));
		end
		settle();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin
					hf = 8'h00; hs = 8'h00; tr = 8'h00;
				end
				1: begin
					hf = 8'hFF; hs = 8'hFF; tr = 8'hFF;
				end
				2: begin
					hf = 8'hFF; hs = 8'h00; tr = 8'h80;
				end
				default: begin
					hf = 8'($urandom_range(0, 255));
					hs = 8'($urandom_range(0, 255));
					tr = 8'($urandom_range(0, 255));
				end
			endcase
			quiet = (p == 2);
			load_regs(hf, hs, tr);
			send_random(PHASE_BYTES);
			settle();
		end

		$display("sent %0d bytes under %0d header/trailer settings, %0d frame bytes checked",
			bytes_sent, settings_used, beats_checked);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/ffa_pkg.sv
hdl/ffa_mem.sv
hdl/fixed_frame_aligner.sv
verif/fixed_frame_aligner_test.sv
